>>> hw/rtl/xdvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xdvd_pkg
// shared types and constants of the xor-delta viewport decoder
// ----------------------------------------------------------------------------
package xdvd_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH          = 4;
    localparam int CFG_ADDR_BITS        = 4;
    localparam int CFG_DATA_BITS        = 32;
    localparam int IN_TDATA_BITS        = 16;
    localparam int OUT_TDATA_BITS       = 40;

    localparam logic [16:0] WIDTH_ZERO_EFF = 17'h10000;

    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH    = 2'd1;
    localparam logic [1:0] REG_ROW_PITCH    = 2'd2;
    localparam logic [1:0] REG_XOR_MODE     = 2'd3;

    localparam logic [23:0] BASE_ADDRESS_RESET = 24'd0;
    localparam logic [15:0] ROW_WIDTH_RESET    = 16'd320;
    localparam logic [15:0] ROW_PITCH_RESET    = 16'd320;
    localparam logic        XOR_MODE_RESET     = 1'b1;

    typedef enum logic [1:0] {
        KIND_FILL,
        KIND_LITERAL,
        KIND_WORD,
        KIND_SKIP
    } cmd_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CMD,
        PH_SFILL_COUNT,
        PH_SFILL_VALUE,
        PH_WORD_LO,
        PH_WORD_HI,
        PH_LFILL_VALUE,
        PH_FILL_RUN,
        PH_LIT_RUN,
        PH_SKIP_WRAP
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic       byte_valid;
        logic [7:0] delta_byte;
        cmd_kind_t  kind;
    } cmd_item_t;

    typedef struct packed {
        logic [23:0] base_address;
        logic [15:0] row_width;
        logic [15:0] row_pitch;
        logic        xor_mode;
    } cfg_t;

    // first field in the highest bits
    typedef struct packed {
        logic        done_res;
        logic        write_merge_xor;
        logic [7:0]  write_data;
        logic [23:0] write_address;
        logic        write_valid;
        logic        byte_taken;
    } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/xdvd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xdvd_front
// unpacks input transfers and classifies the command byte
// ----------------------------------------------------------------------------
module xdvd_front (
    input  wire logic [xdvd_pkg::IN_TDATA_BITS-1:0] s_tdata,
    output xdvd_pkg::cmd_item_t                     item
);
    import xdvd_pkg::*;

    logic [7:0] data_byte;

    assign data_byte = s_tdata[9:2];

    always_comb begin
        item.start_req  = s_tdata[0];
        item.byte_valid = s_tdata[1];
        item.delta_byte = data_byte;
        priority if (data_byte == 8'h00) begin
            item.kind = KIND_FILL;
        end else if (!data_byte[7]) begin
            item.kind = KIND_LITERAL;
        end else if (data_byte[6:0] == 7'h00) begin
            item.kind = KIND_WORD;
        end else begin
            item.kind = KIND_SKIP;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/xdvd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xdvd_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module xdvd_queue #(
    parameter int DEPTH = xdvd_pkg::QUEUE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire xdvd_pkg::cmd_item_t in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output xdvd_pkg::cmd_item_t      out_item
);
    import xdvd_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_item_t             mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS:0]     count_reg;
    logic                  push;
    logic                  pop;

    assign in_ready  = (count_reg != (PTR_BITS + 1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/xdvd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xdvd_back
// decode state machine, write address generation and result register
// ----------------------------------------------------------------------------
module xdvd_back #(
    parameter int ADDRESS_BITS = xdvd_pkg::ADDRESS_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire xdvd_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire xdvd_pkg::cmd_item_t in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output xdvd_pkg::result_t        out_res
);
    import xdvd_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [16:0]             column_reg, column_next;
    logic [ADDRESS_BITS-1:0] row_start_reg, row_start_next;
    logic [14:0]             run_left_reg, run_left_next;
    logic [7:0]              fill_byte_reg, fill_byte_next;
    logic [7:0]              low_byte_reg, low_byte_next;
    logic                    out_valid_reg;
    result_t                 out_res_reg, res_next;

    logic                    pop;
    logic [16:0]             eff_width;
    logic [15:0]             word;
    logic [15:0]             skip_amt;
    logic [16:0]             col_skip;
    logic [16:0]             col_inc;
    logic [16:0]             col_wrap;
    logic [14:0]             run_dec;
    logic [ADDRESS_BITS-1:0] next_row_addr;
    logic [ADDRESS_BITS-1:0] emit_addr;
    logic                    do_emit;
    logic                    do_skip;
    logic [7:0]              emit_data;

    assign in_ready  = !out_valid_reg || out_ready;
    assign pop       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb begin
        eff_width     = (cfg.row_width == 16'd0) ? WIDTH_ZERO_EFF : {1'b0, cfg.row_width};
        word          = {in_item.delta_byte, low_byte_reg};
        skip_amt      = (phase_reg == PH_WORD_HI) ? word : {9'd0, in_item.delta_byte[6:0]};
        col_skip      = column_reg + {1'b0, skip_amt};
        col_inc       = column_reg + 17'd1;
        col_wrap      = column_reg - eff_width;
        run_dec       = run_left_reg - 15'd1;
        next_row_addr = row_start_reg + ADDRESS_BITS'(cfg.row_pitch);
        emit_addr     = row_start_reg + ADDRESS_BITS'(column_reg);

        phase_next     = phase_reg;
        column_next    = column_reg;
        row_start_next = row_start_reg;
        run_left_next  = run_left_reg;
        fill_byte_next = fill_byte_reg;
        low_byte_next  = low_byte_reg;
        res_next       = '0;
        do_emit        = 1'b0;
        do_skip        = 1'b0;
        emit_data      = in_item.delta_byte;

        if (in_item.start_req) begin
            row_start_next = ADDRESS_BITS'(cfg.base_address);
            column_next    = '0;
            run_left_next  = '0;
            phase_next     = PH_CMD;
        end else begin
            unique case (phase_reg)
                PH_CMD: begin
                    if (in_item.byte_valid) begin
                        res_next.byte_taken = 1'b1;
                        unique case (in_item.kind)
                            KIND_FILL: phase_next = PH_SFILL_COUNT;
                            KIND_LITERAL: begin
                                run_left_next = {7'd0, in_item.delta_byte};
                                phase_next    = PH_LIT_RUN;
                            end
                            KIND_WORD: phase_next = PH_WORD_LO;
                            KIND_SKIP: do_skip = 1'b1;
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                end
                PH_SFILL_COUNT: begin
                    if (in_item.byte_valid) begin
                        res_next.byte_taken = 1'b1;
                        run_left_next       = {7'd0, in_item.delta_byte};
                        phase_next          = PH_SFILL_VALUE;
                    end
                end
                PH_SFILL_VALUE, PH_LFILL_VALUE: begin
                    if (in_item.byte_valid) begin
                        res_next.byte_taken = 1'b1;
                        fill_byte_next      = in_item.delta_byte;
                        phase_next          = (run_left_reg != '0) ? PH_FILL_RUN : PH_CMD;
                    end
                end
                PH_WORD_LO: begin
                    if (in_item.byte_valid) begin
                        res_next.byte_taken = 1'b1;
                        low_byte_next       = in_item.delta_byte;
                        phase_next          = PH_WORD_HI;
                    end
                end
                PH_WORD_HI: begin
                    if (in_item.byte_valid) begin
                        res_next.byte_taken = 1'b1;
                        priority if (word == 16'd0) begin
                            res_next.done_res = 1'b1;
                            phase_next        = PH_IDLE;
                        end else if (!word[15]) begin
                            do_skip = 1'b1;
                        end else if (word[14]) begin
                            run_left_next = {1'b0, word[13:0]};
                            phase_next    = PH_LFILL_VALUE;
                        end else begin
                            run_left_next = {1'b0, word[13:0]};
                            phase_next    = (word[13:0] != '0) ? PH_LIT_RUN : PH_CMD;
                        end
                    end
                end
                PH_FILL_RUN: begin
                    if (run_left_reg == '0) begin
                        phase_next = PH_CMD;
                    end else begin
                        do_emit   = 1'b1;
                        emit_data = fill_byte_reg;
                    end
                end
                PH_LIT_RUN: begin
                    if (run_left_reg == '0) begin
                        phase_next = PH_CMD;
                    end else if (in_item.byte_valid) begin
                        res_next.byte_taken = 1'b1;
                        do_emit             = 1'b1;
                    end
                end
                PH_SKIP_WRAP: begin
                    if (column_reg >= eff_width) begin
                        column_next    = col_wrap;
                        row_start_next = next_row_addr;
                        if (col_wrap < eff_width) begin
                            phase_next = PH_CMD;
                        end
                    end else begin
                        phase_next = PH_CMD;
                    end
                end
                PH_IDLE: begin
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        if (do_skip) begin
            column_next = col_skip;
            phase_next  = (col_skip >= eff_width) ? PH_SKIP_WRAP : PH_CMD;
        end

        if (do_emit) begin
            res_next.write_valid     = 1'b1;
            res_next.write_address   = 24'(emit_addr);
            res_next.write_data      = emit_data;
            res_next.write_merge_xor = cfg.xor_mode;
            if (col_inc >= eff_width) begin
                column_next    = '0;
                row_start_next = next_row_addr;
            end else begin
                column_next = col_inc;
            end
            run_left_next = run_dec;
            if (run_dec == '0) begin
                phase_next = PH_CMD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            column_reg    <= '0;
            row_start_reg <= '0;
            run_left_reg  <= '0;
            fill_byte_reg <= '0;
            low_byte_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg     <= phase_next;
                column_reg    <= column_next;
                row_start_reg <= row_start_next;
                run_left_reg  <= run_left_next;
                fill_byte_reg <= fill_byte_next;
                low_byte_reg  <= low_byte_next;
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_res_reg <= res_next;
        end
    end

`ifndef SYNTH
    // a start request always lands at column zero ready for a command
    a_start_restarts : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && in_item.start_req) |=> (phase_reg == PH_CMD && column_reg == '0
            && out_valid_reg && !out_res_reg.byte_taken && !out_res_reg.write_valid))
        else $error("start request did not restart decoding");

    // a pending fill run writes on every transfer
    a_fill_writes : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !in_item.start_req && phase_reg == PH_FILL_RUN && run_left_reg != '0)
            |=> (out_res_reg.write_valid && !out_res_reg.byte_taken))
        else $error("fill run step without a write");

    // idle decoder neither takes bytes nor writes
    a_idle_quiet : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !in_item.start_req && phase_reg == PH_IDLE)
            |=> (out_res_reg == '0 && phase_reg == PH_IDLE))
        else $error("activity while idle");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/xor_delta_viewport_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xor_delta_viewport_decoder
// xor-delta command stream to framebuffer window byte writes
// ----------------------------------------------------------------------------
// Each input transfer is one decoder tick and gives exactly one output
// transfer, at one tick per clock cycle sustained while m_tready stays high. A
// tick leaves the front classifier through a four-entry queue into the decode
// state machine, whose state update sets the rate; its result sits in an output
// register. Configuration registers lie at byte addresses 0, 4, 8 and 12 and
// take effect at once.
// ----------------------------------------------------------------------------
module xor_delta_viewport_decoder #(
    parameter int ADDRESS_BITS = xdvd_pkg::ADDRESS_BITS_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // start_req, byte_valid, delta_byte
    input  wire logic [xdvd_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // byte_taken, write_valid, write_address, write_data, write_merge_xor, done_res
    output logic [xdvd_pkg::OUT_TDATA_BITS-1:0]       m_tdata,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [xdvd_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  wire logic [xdvd_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [xdvd_pkg::CFG_DATA_BITS-1:0]        prdata,
    output logic                                      pready
);
    import xdvd_pkg::*;

    cfg_t      cfg_reg;
    cmd_item_t front_item;
    cmd_item_t back_item;
    logic      back_valid;
    logic      back_ready;
    result_t   res;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_address <= BASE_ADDRESS_RESET;
            cfg_reg.row_width    <= ROW_WIDTH_RESET;
            cfg_reg.row_pitch    <= ROW_PITCH_RESET;
            cfg_reg.xor_mode     <= XOR_MODE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_BASE_ADDRESS: cfg_reg.base_address <= pwdata[23:0];
                REG_ROW_WIDTH:    cfg_reg.row_width    <= pwdata[15:0];
                REG_ROW_PITCH:    cfg_reg.row_pitch    <= pwdata[15:0];
                REG_XOR_MODE:     cfg_reg.xor_mode     <= pwdata[0];
                default:          cfg_reg.xor_mode     <= cfg_reg.xor_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BASE_ADDRESS: prdata = CFG_DATA_BITS'(cfg_reg.base_address);
            REG_ROW_WIDTH:    prdata = CFG_DATA_BITS'(cfg_reg.row_width);
            REG_ROW_PITCH:    prdata = CFG_DATA_BITS'(cfg_reg.row_pitch);
            REG_XOR_MODE:     prdata = CFG_DATA_BITS'(cfg_reg.xor_mode);
            default:          prdata = '0;
        endcase
    end

    xdvd_front u_front (
        .s_tdata (s_tdata),
        .item    (front_item)
    );

    xdvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    xdvd_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (back_valid),
        .in_ready  (back_ready),
        .in_item   (back_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = OUT_TDATA_BITS'(res);

endmodule
`default_nettype wire
